@@ rtl/mlpbg_pkg.sv @@
// Shared types and constants for the legato pitch-bend glide block.
// Used by the front, divider, back and top modules; has no dependencies of its own.
package mlpbg_pkg;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  midi_status;
        logic [6:0]  midi_data1;
        logic [6:0]  midi_data2;
        logic [19:0] elapsed_us;
    } in_t;

    typedef struct packed {
        logic [7:0] out_status;
        logic [6:0] out_data1;
        logic [6:0] out_data2;
        logic       last_of_run;
    } out_t;

    typedef struct packed {
        logic [23:0] bend_time_us;
        logic        curve_mode;
    } cfg_t;

    typedef struct packed {
        logic        is_tick;
        logic [19:0] elapsed;
        logic [7:0]  status;
        logic [6:0]  data1;
        logic [6:0]  data2;
        logic        ch_ok;
        logic        is_cc_range;
        logic        is_on;
        logic        is_off;
    } item_t;

    localparam logic [7:0]  ST_NOTE_OFF   = 8'h80;
    localparam logic [7:0]  ST_NOTE_ON    = 8'h90;
    localparam logic [7:0]  ST_CC         = 8'hB0;
    localparam logic [7:0]  ST_BEND       = 8'hE0;
    localparam logic [7:0]  ST_TYPE_MASK  = 8'hF0;
    localparam logic [6:0]  CC_BEND_RANGE = 7'h14;
    localparam logic [6:0]  NEUTRAL       = 7'd64;
    localparam logic [6:0]  MAX7          = 7'd127;
    localparam logic [7:0]  NO_TARGET     = 8'hFF;
    localparam logic [22:0] NEUTRAL_Q16   = 23'h400000;
    localparam logic [22:0] MAX_Q16       = 23'h7F0000;
    localparam logic [16:0] P_ONE         = 17'h10000;
    localparam logic [17:0] THREE_Q16     = 18'h30000;
    localparam logic [4:0]  DIV_STEPS     = 5'd16;

    localparam logic REG_BEND_TIME = 1'b0;
    localparam logic REG_CURVE     = 1'b1;

endpackage

@@ rtl/mlpbg_queue.sv @@
// Small register queue between the front and back parts.
// Depends on nothing but its parameters.
module mlpbg_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [CW-1:0]    count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

@@ rtl/mlpbg_front.sv @@
// Input side: accepts items and classifies each MIDI event before queueing.
// Depends on mlpbg_pkg.
module mlpbg_front #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic            s_valid,
    output logic            s_ready,
    input  mlpbg_pkg::in_t  s_data,
    input  logic            q_full,
    output logic            q_push,
    output mlpbg_pkg::item_t q_item
);
    import mlpbg_pkg::*;

    logic [7:0] msg_type;

    assign s_ready  = !q_full;
    assign q_push   = s_valid && !q_full;
    assign msg_type = s_data.midi_status & ST_TYPE_MASK;

    always_comb begin
        q_item.is_tick     = s_data.req_type;
        q_item.elapsed     = s_data.elapsed_us;
        q_item.status      = s_data.midi_status;
        q_item.data1       = s_data.midi_data1;
        q_item.data2       = s_data.midi_data2;
        q_item.ch_ok       = {1'b0, s_data.midi_status[3:0]} < 5'(NUM_CHANNELS);
        q_item.is_cc_range = (msg_type == ST_CC) && (s_data.midi_data1 == CC_BEND_RANGE);
        q_item.is_on       = (msg_type == ST_NOTE_ON) && (s_data.midi_data2 != '0);
        q_item.is_off      = (msg_type == ST_NOTE_OFF) ||
                             ((msg_type == ST_NOTE_ON) && (s_data.midi_data2 == '0));
    end
endmodule

@@ rtl/mlpbg_div.sv @@
// Restoring divider, one quotient bit per cycle, sixteen bits per run.
// Depends on mlpbg_pkg.
module mlpbg_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] rem_init,
    input  logic [15:0] dividend,
    input  logic [23:0] divisor,
    output logic        done,
    output logic [15:0] quot
);
    import mlpbg_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [23:0] rem_reg;
    logic [15:0] sh_reg;
    logic [23:0] dvs_reg;
    logic [24:0] trial;
    logic        fit;

    assign trial = {rem_reg, sh_reg[15]};
    assign fit   = trial >= {1'b0, dvs_reg};
    assign done  = done_reg;
    assign quot  = sh_reg;

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rem_reg <= rem_init;
            sh_reg  <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fit ? 24'(trial - {1'b0, dvs_reg}) : trial[23:0];
            sh_reg  <= {sh_reg[14:0], fit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_STEPS;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

@@ rtl/mlpbg_back.sv @@
// Back part: per-channel phrase and ramp state, event sequencer and tick walk.
// Depends on mlpbg_pkg and mlpbg_div.
module mlpbg_back #(
    parameter int           NUM_CHANNELS       = 16,
    parameter logic [6:0]   DEFAULT_BEND_RANGE = 7'd2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  mlpbg_pkg::cfg_t  cfg,
    input  logic             q_empty,
    input  mlpbg_pkg::item_t q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output mlpbg_pkg::out_t  m_data
);
    import mlpbg_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EV    = 4'd1;
    localparam logic [3:0] S_EV2   = 4'd2;
    localparam logic [3:0] S_EVDIV = 4'd3;
    localparam logic [3:0] S_TCHK  = 4'd4;
    localparam logic [3:0] S_TDIV  = 4'd5;
    localparam logic [3:0] S_TSQ   = 4'd6;
    localparam logic [3:0] S_TSM   = 4'd7;
    localparam logic [3:0] S_TMUL  = 4'd8;
    localparam logic [3:0] S_TACC  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic        chan_act_reg  [0:NUM_CHANNELS-1];
    logic        held_reg      [0:NUM_CHANNELS-1];
    logic [6:0]  anchor_reg    [0:NUM_CHANNELS-1];
    logic [7:0]  target_reg    [0:NUM_CHANNELS-1];
    logic [6:0]  range_reg     [0:NUM_CHANNELS-1];
    logic [22:0] cur_bend_reg  [0:NUM_CHANNELS-1];
    logic [6:0]  last_reg      [0:NUM_CHANNELS-1];
    logic        ramp_act_reg  [0:NUM_CHANNELS-1];
    logic [22:0] ramp_from_reg [0:NUM_CHANNELS-1];
    logic [6:0]  ramp_to_reg   [0:NUM_CHANNELS-1];
    logic [23:0] ramp_el_reg   [0:NUM_CHANNELS-1];
    logic [23:0] ramp_dur_reg  [0:NUM_CHANNELS-1];
    logic        ramp_crv_reg  [0:NUM_CHANNELS-1];

    logic [3:0]         state_reg;
    item_t              cur_reg;
    logic [CH_W-1:0]    tch_reg;
    logic               pend_valid_reg;
    out_t               pend_reg;
    out_t               sec_reg;
    logic               m_valid_reg;
    out_t               m_data_reg;
    logic               neg_reg;
    logic [16:0]        p_reg;
    logic [16:0]        sq_reg;
    logic [16:0]        s_reg;
    logic signed [42:0] delta_reg;

    logic [CH_W-1:0] cidx;
    logic [3:0]      ch_nib;
    logic            tick_state;
    logic            act_rd, held_rd, ract_rd, rcrv_rd;
    logic [6:0]      anchor_rd, range_rd, last_rd, rto_rd;
    logic [7:0]      tgt_rd;
    logic [22:0]     cur_rd, from_rd;
    logic [23:0]     el_rd, dur_rd;

    logic bt_on, n1;
    logic ev_pass, ev_new, ev_tgt, ev_anc, anc_end, ev_rel, rel_held, rel_end, ramp_go;
    logic sec_req;
    out_t pass_res, neut_res, off_res, sec_data;
    logic [6:0]  rnote;
    logic [7:0]  semis;
    logic [6:0]  semis_abs;
    logic [13:0] div_num;
    logic [6:0]  tv;

    logic [24:0] el_sum;
    logic [23:0] el_new;
    logic [33:0] sq_full;
    logic [17:0] w_fac;
    logic [34:0] sm_full;
    logic signed [24:0] diff;
    logic signed [42:0] delta;
    logic        dneg;
    logic [42:0] absd;
    logic [26:0] magr;
    logic [27:0] up_sum;
    logic [22:0] curv;
    logic [23:0] bsum;
    logic [6:0]  bval;
    logic        ended;

    logic        em_req, emit_ok, em_fire, advance, out_free, out_push, fin_push;
    out_t        em_data, out_data;

    logic        div_start, div_done;
    logic [23:0] div_rem, div_dvs;
    logic [15:0] div_dvd, div_quot;

    mlpbg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign tick_state = (state_reg == S_TCHK) || (state_reg == S_TDIV) ||
                        (state_reg == S_TSQ) || (state_reg == S_TSM) ||
                        (state_reg == S_TMUL) || (state_reg == S_TACC);

    always_comb begin
        cidx = '0;
        if (tick_state) begin
            cidx = tch_reg;
        end else if (cur_reg.ch_ok) begin
            cidx = cur_reg.status[CH_W-1:0];
        end
    end

    assign ch_nib    = tick_state ? 4'(tch_reg) : cur_reg.status[3:0];
    assign act_rd    = chan_act_reg[cidx];
    assign held_rd   = held_reg[cidx];
    assign anchor_rd = anchor_reg[cidx];
    assign tgt_rd    = target_reg[cidx];
    assign range_rd  = range_reg[cidx];
    assign cur_rd    = cur_bend_reg[cidx];
    assign last_rd   = last_reg[cidx];
    assign ract_rd   = ramp_act_reg[cidx];
    assign from_rd   = ramp_from_reg[cidx];
    assign rto_rd    = ramp_to_reg[cidx];
    assign el_rd     = ramp_el_reg[cidx];
    assign dur_rd    = ramp_dur_reg[cidx];
    assign rcrv_rd   = ramp_crv_reg[cidx];

    // Event classification against the channel's current phrase state.
    always_comb begin
        bt_on    = cfg.bend_time_us != '0;
        n1       = last_rd != NEUTRAL;
        ev_pass  = !bt_on || !cur_reg.ch_ok || cur_reg.is_cc_range ||
                   (!cur_reg.is_on && !cur_reg.is_off) || (cur_reg.is_off && !act_rd);
        ev_new   = !ev_pass && cur_reg.is_on && !act_rd;
        ev_tgt   = !ev_pass && cur_reg.is_on && act_rd;
        ev_anc   = !ev_pass && cur_reg.is_off && (cur_reg.data1 == anchor_rd);
        anc_end  = ev_anc && (tgt_rd == NO_TARGET);
        ev_rel   = !ev_pass && cur_reg.is_off && (cur_reg.data1 != anchor_rd) &&
                   (tgt_rd == {1'b0, cur_reg.data1});
        rel_held = ev_rel && held_rd;
        rel_end  = ev_rel && !held_rd;
        ramp_go  = ev_tgt || rel_held;

        pass_res = '{out_status: cur_reg.status, out_data1: cur_reg.data1,
                     out_data2: cur_reg.data2, last_of_run: 1'b0};
        neut_res = '{out_status: ST_BEND | {4'h0, ch_nib}, out_data1: 7'd0,
                     out_data2: NEUTRAL, last_of_run: 1'b0};
        off_res  = '{out_status: ST_NOTE_OFF | {4'h0, ch_nib}, out_data1: anchor_rd,
                     out_data2: 7'd0, last_of_run: 1'b0};
        sec_req  = (ev_new || anc_end) && n1;
        sec_data = ev_new ? pass_res : neut_res;

        rnote     = ev_tgt ? cur_reg.data1 : anchor_rd;
        semis     = {1'b0, rnote} - {1'b0, anchor_rd};
        semis_abs = semis[7] ? 7'(-semis) : semis[6:0];
        div_num   = {semis_abs, 7'd0} + {7'd0, range_rd};

        if (neg_reg) begin
            tv = (div_quot > 16'd64) ? 7'd0 : 7'(16'd64 - div_quot);
        end else begin
            tv = (div_quot > 16'd63) ? MAX7 : 7'(16'd64 + div_quot);
        end
    end

    // Ramp arithmetic for the channel under the tick walk.
    always_comb begin
        el_sum  = {1'b0, el_rd} + 25'(cur_reg.elapsed);
        el_new  = (el_sum > {1'b0, dur_rd}) ? dur_rd : el_sum[23:0];
        sq_full = p_reg * p_reg;
        w_fac   = THREE_Q16 - {p_reg, 1'b0};
        sm_full = sq_reg * w_fac;
        diff    = $signed({2'b00, rto_rd, 16'h0000}) - $signed({2'b00, from_rd});
        delta   = diff * $signed({1'b0, s_reg});
        dneg    = delta_reg[42];
        absd    = dneg ? 43'(-delta_reg) : 43'(delta_reg);
        magr    = 27'((44'(absd) + 44'd32768) >> 16);
        up_sum  = 28'(from_rd) + 28'(magr);
        if (dneg) begin
            curv = (magr > 27'(from_rd)) ? 23'd0 : 23'(27'(from_rd) - magr);
        end else begin
            curv = (up_sum > 28'(MAX_Q16)) ? MAX_Q16 : up_sum[22:0];
        end
        bsum  = {1'b0, curv} + 24'd32768;
        bval  = (bsum[23:16] > 8'd127) ? MAX7 : bsum[22:16];
        ended = el_rd >= dur_rd;
    end

    always_comb begin
        em_req  = 1'b0;
        em_data = pass_res;
        unique case (state_reg)
            S_EV: begin
                if (ev_pass) begin
                    em_req = 1'b1;
                end else if (ev_new) begin
                    em_req  = 1'b1;
                    em_data = n1 ? neut_res : pass_res;
                end else if (anc_end) begin
                    em_req = 1'b1;
                end else if (rel_end) begin
                    em_req  = 1'b1;
                    em_data = off_res;
                end
            end
            S_EV2: begin
                em_req  = 1'b1;
                em_data = sec_reg;
            end
            S_TACC: begin
                em_req  = bval != last_rd;
                em_data = '{out_status: ST_BEND | {4'h0, ch_nib}, out_data1: 7'd0,
                            out_data2: bval, last_of_run: 1'b0};
            end
            default: begin
                em_req = 1'b0;
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign em_fire  = em_req && emit_ok;
    assign advance  = !em_req || emit_ok;
    assign fin_push = (state_reg == S_FIN) && pend_valid_reg && out_free;
    assign out_push = (em_fire && pend_valid_reg) || fin_push;
    assign out_data = '{out_status: pend_reg.out_status, out_data1: pend_reg.out_data1,
                        out_data2: pend_reg.out_data2, last_of_run: fin_push};

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    always_comb begin
        div_start = 1'b0;
        div_rem   = '0;
        div_dvd   = 16'(div_num);
        div_dvs   = {16'h0000, range_rd, 1'b0};
        if (state_reg == S_EV) begin
            div_start = ramp_go && (range_rd != '0);
        end else if (state_reg == S_TCHK) begin
            div_start = ract_rd && (el_new != dur_rd);
            div_rem   = el_new;
            div_dvd   = '0;
            div_dvs   = dur_rd;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && !q_empty) begin
            cur_reg <= q_head;
        end
        if (em_fire) begin
            pend_reg <= em_data;
        end
        if (out_push) begin
            m_data_reg <= out_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            tch_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                chan_act_reg[i]  <= 1'b0;
                held_reg[i]      <= 1'b0;
                anchor_reg[i]    <= '0;
                target_reg[i]    <= NO_TARGET;
                range_reg[i]     <= DEFAULT_BEND_RANGE;
                cur_bend_reg[i]  <= NEUTRAL_Q16;
                last_reg[i]      <= NEUTRAL;
                ramp_act_reg[i]  <= 1'b0;
                ramp_from_reg[i] <= NEUTRAL_Q16;
                ramp_to_reg[i]   <= NEUTRAL;
                ramp_el_reg[i]   <= '0;
                ramp_dur_reg[i]  <= '0;
                ramp_crv_reg[i]  <= 1'b0;
            end
        end else begin
            if (out_push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (em_fire) begin
                pend_valid_reg <= 1'b1;
            end else if (fin_push) begin
                pend_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        tch_reg <= '0;
                        if (!q_head.is_tick) begin
                            state_reg <= S_EV;
                        end else if (q_head.elapsed == '0) begin
                            state_reg <= S_FIN;
                        end else begin
                            state_reg <= S_TCHK;
                        end
                    end
                end
                S_EV: begin
                    if (advance) begin
                        if (bt_on && cur_reg.ch_ok && cur_reg.is_cc_range) begin
                            range_reg[cidx] <= cur_reg.data2;
                        end
                        if ((ev_new || anc_end) && n1) begin
                            cur_bend_reg[cidx] <= NEUTRAL_Q16;
                            last_reg[cidx]     <= NEUTRAL;
                        end
                        if (ev_new || anc_end || rel_end) begin
                            chan_act_reg[cidx]  <= ev_new;
                            held_reg[cidx]      <= ev_new;
                            anchor_reg[cidx]    <= ev_new ? cur_reg.data1 : '0;
                            target_reg[cidx]    <= NO_TARGET;
                            ramp_act_reg[cidx]  <= 1'b0;
                            ramp_from_reg[cidx] <= NEUTRAL_Q16;
                            ramp_to_reg[cidx]   <= NEUTRAL;
                            ramp_el_reg[cidx]   <= '0;
                            ramp_dur_reg[cidx]  <= '0;
                            ramp_crv_reg[cidx]  <= 1'b0;
                        end
                        if (ev_anc && !anc_end) begin
                            held_reg[cidx] <= 1'b0;
                        end
                        if (ev_tgt) begin
                            target_reg[cidx] <= {1'b0, cur_reg.data1};
                        end
                        if (rel_held) begin
                            target_reg[cidx] <= NO_TARGET;
                        end
                        if (ramp_go) begin
                            ramp_act_reg[cidx]  <= 1'b1;
                            ramp_from_reg[cidx] <= cur_rd;
                            ramp_el_reg[cidx]   <= '0;
                            ramp_dur_reg[cidx]  <= cfg.bend_time_us;
                            ramp_crv_reg[cidx]  <= cfg.curve_mode;
                            if (range_rd == '0) begin
                                ramp_to_reg[cidx] <= NEUTRAL;
                            end
                        end
                        neg_reg <= semis[7];
                        sec_reg <= sec_data;
                        if (ramp_go && (range_rd != '0)) begin
                            state_reg <= S_EVDIV;
                        end else if (sec_req) begin
                            state_reg <= S_EV2;
                        end else begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_EV2: begin
                    if (advance) begin
                        state_reg <= S_FIN;
                    end
                end
                S_EVDIV: begin
                    if (div_done) begin
                        ramp_to_reg[cidx] <= tv;
                        state_reg         <= S_FIN;
                    end
                end
                S_TCHK: begin
                    if (!ract_rd) begin
                        if (tch_reg == LAST_CH) begin
                            state_reg <= S_FIN;
                        end else begin
                            tch_reg <= tch_reg + 1'b1;
                        end
                    end else begin
                        ramp_el_reg[cidx] <= el_new;
                        if (el_new == dur_rd) begin
                            p_reg     <= P_ONE;
                            state_reg <= S_TSQ;
                        end else begin
                            state_reg <= S_TDIV;
                        end
                    end
                end
                S_TDIV: begin
                    if (div_done) begin
                        p_reg     <= {1'b0, div_quot};
                        state_reg <= S_TSQ;
                    end
                end
                S_TSQ: begin
                    if (rcrv_rd) begin
                        sq_reg    <= sq_full[32:16];
                        state_reg <= S_TSM;
                    end else begin
                        s_reg     <= p_reg;
                        state_reg <= S_TMUL;
                    end
                end
                S_TSM: begin
                    s_reg     <= sm_full[32:16];
                    state_reg <= S_TMUL;
                end
                S_TMUL: begin
                    delta_reg <= delta;
                    state_reg <= S_TACC;
                end
                S_TACC: begin
                    if (advance) begin
                        if (em_req) begin
                            last_reg[cidx] <= bval;
                        end
                        if (ended) begin
                            cur_bend_reg[cidx] <= {rto_rd, 16'h0000};
                            ramp_act_reg[cidx] <= 1'b0;
                        end else begin
                            cur_bend_reg[cidx] <= curv;
                        end
                        if (tch_reg == LAST_CH) begin
                            state_reg <= S_FIN;
                        end else begin
                            tch_reg   <= tch_reg + 1'b1;
                            state_reg <= S_TCHK;
                        end
                    end
                end
                S_FIN: begin
                    if (!pend_valid_reg || out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

@@ rtl/midi_legato_pitch_bend_glide.sv @@
// An accepted event passes the queue, the back part's item register and its pending
// result register before its first result is valid; a second result may follow;
// an event that starts a ramp emits nothing and holds the back part while the 16-step
// divider scales the target. A tick walks the channels in turn, checking each one; a
// ramping channel also runs the divider (unless its ramp ends) and the multiplies.
// Synchronous active-low reset clears all channel state and the queue.
module midi_legato_pitch_bend_glide #(
    parameter int         NUM_CHANNELS       = 16,
    parameter logic [6:0] DEFAULT_BEND_RANGE = 7'd2,
    parameter int         QUEUE_DEPTH        = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [23:0]     cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  mlpbg_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output mlpbg_pkg::out_t m_data
);
    import mlpbg_pkg::*;

    cfg_t  cfg_reg;
    logic  q_push, q_full, q_pop, q_empty;
    item_t q_item, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BEND_TIME: cfg_reg.bend_time_us <= cfg_wdata;
                REG_CURVE:     cfg_reg.curve_mode   <= cfg_wdata[0];
                default:       cfg_reg              <= cfg_reg;
            endcase
        end
    end

    mlpbg_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_item)
    );

    mlpbg_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(item_t))
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_item),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rdata   (q_head)
    );

    mlpbg_back #(
        .NUM_CHANNELS       (NUM_CHANNELS),
        .DEFAULT_BEND_RANGE (DEFAULT_BEND_RANGE)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty) else $error("Queue popped while empty.");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full) else $error("Queue pushed while full.");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("Result valid right after reset.");
endmodule

@@ tb/mlpbg_glide_checker.sv @@
`timescale 1ns / 1ps
// Checker for the legato pitch-bend glide block: watches the config port and both
// channels, predicts the results of every accepted item and compares them in order.
// Depends on mlpbg_pkg for the item types and the MIDI constants.
module mlpbg_glide_checker #(
    parameter int         NUM_CHANNELS       = 16,
    parameter logic [6:0] DEFAULT_BEND_RANGE = 7'd2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [23:0]     cfg_wdata,
    input  logic            s_valid,
    input  logic            s_ready,
    input  mlpbg_pkg::in_t  s_data,
    input  logic            m_valid,
    input  logic            m_ready,
    input  mlpbg_pkg::out_t m_data,
    output int              fail_count,
    output int              pending_count,
    output int              result_count
);
    import mlpbg_pkg::*;

    localparam int ONE_Q16 = 65536;

    logic [23:0] glide_time;
    logic        glide_smooth;

    logic        phrase_on   [16];
    logic        anchor_down [16];
    logic [6:0]  anchor      [16];
    logic [7:0]  target      [16];
    logic [6:0]  range_semis [16];
    int unsigned bend_q16    [16];
    logic [6:0]  sent_bend   [16];
    logic        ramping     [16];
    int unsigned ramp_start  [16];
    logic [6:0]  ramp_goal   [16];
    int unsigned ramp_spent  [16];
    int unsigned ramp_len    [16];
    logic        ramp_smooth [16];

    out_t expected_msgs[$];
    int   new_msgs;

    function automatic void push_msg(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
        out_t o;
        o.out_status  = st;
        o.out_data1   = d1;
        o.out_data2   = d2;
        o.last_of_run = 1'b0;
        expected_msgs.insert(expected_msgs.size(), o);
        new_msgs++;
    endfunction

    function automatic void end_phrase(int ch);
        phrase_on[ch]   = 1'b0;
        anchor_down[ch] = 1'b0;
        anchor[ch]      = '0;
        target[ch]      = NO_TARGET;
        ramping[ch]     = 1'b0;
        ramp_start[ch]  = 64 * ONE_Q16;
        ramp_goal[ch]   = NEUTRAL;
        ramp_spent[ch]  = 0;
        ramp_len[ch]    = 0;
        ramp_smooth[ch] = 1'b0;
    endfunction

    function automatic void recenter(int ch);
        if (sent_bend[ch] != NEUTRAL) begin
            push_msg(ST_BEND | 8'(ch), 7'd0, NEUTRAL);
            bend_q16[ch]  = 64 * ONE_Q16;
            sent_bend[ch] = NEUTRAL;
            ramping[ch]   = 1'b0;
        end
    endfunction

    function automatic logic [6:0] bend_for_note(int ch, int note);
        int semis;
        int mag;
        int q;
        int v;
        if (range_semis[ch] == 0)
            return NEUTRAL;
        semis = note - int'(anchor[ch]);
        mag = (semis < 0 ? -semis : semis) * 64;
        q = (2 * mag + int'(range_semis[ch])) / (2 * int'(range_semis[ch]));
        v = 64 + (semis < 0 ? -q : q);
        if (v < 0) v = 0;
        if (v > 127) v = 127;
        return 7'(v);
    endfunction

    function automatic void start_glide(int ch, int note);
        ramping[ch]     = 1'b1;
        ramp_start[ch]  = bend_q16[ch];
        ramp_goal[ch]   = bend_for_note(ch, note);
        ramp_spent[ch]  = 0;
        ramp_len[ch]    = glide_time;
        ramp_smooth[ch] = glide_smooth;
    endfunction

    function automatic void advance_glides(int unsigned us);
        longint p, s, q, diff, delta, mag, cur;
        int unsigned b;
        if (us == 0)
            return;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (!ramping[ch])
                continue;
            ramp_spent[ch] += us;
            if (ramp_spent[ch] > ramp_len[ch])
                ramp_spent[ch] = ramp_len[ch];
            if (ramp_len[ch] == 0)
                p = ONE_Q16;
            else
                p = (longint'(ramp_spent[ch]) << 16) / longint'(ramp_len[ch]);
            if (ramp_smooth[ch]) begin
                q = (p * p) >>> 16;
                s = (q * (3 * ONE_Q16 - 2 * p)) >>> 16;
            end else begin
                s = p;
            end
            diff  = longint'(ramp_goal[ch]) * ONE_Q16 - longint'(ramp_start[ch]);
            delta = diff * s;
            mag   = delta < 0 ? -delta : delta;
            mag   = (mag + 32768) >>> 16;
            cur   = longint'(ramp_start[ch]) + (delta < 0 ? -mag : mag);
            if (cur < 0) cur = 0;
            if (cur > 127 * ONE_Q16) cur = 127 * ONE_Q16;
            bend_q16[ch] = int'(cur);
            b = (bend_q16[ch] + 32768) >> 16;
            if (b > 127) b = 127;
            if (7'(b) != sent_bend[ch]) begin
                push_msg(ST_BEND | 8'(ch), 7'd0, 7'(b));
                sent_bend[ch] = 7'(b);
            end
            if (ramp_spent[ch] >= ramp_len[ch]) begin
                bend_q16[ch] = int'(ramp_goal[ch]) * ONE_Q16;
                ramping[ch]  = 1'b0;
            end
        end
    endfunction

    function automatic void handle_event(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
        int ch;
        logic [7:0] kind;
        logic on, off;
        ch   = int'(st[3:0]);
        kind = st & ST_TYPE_MASK;
        if (glide_time == 0 || ch >= NUM_CHANNELS) begin
            push_msg(st, d1, d2);
            return;
        end
        if (kind == ST_CC && d1 == CC_BEND_RANGE) begin
            range_semis[ch] = d2;
            push_msg(st, d1, d2);
            return;
        end
        on  = (kind == ST_NOTE_ON) && d2 != 0;
        off = (kind == ST_NOTE_OFF) || (kind == ST_NOTE_ON && d2 == 0);
        if (!on && !off) begin
            push_msg(st, d1, d2);
            return;
        end
        if (on) begin
            if (!phrase_on[ch]) begin
                recenter(ch);
                end_phrase(ch);
                phrase_on[ch]   = 1'b1;
                anchor_down[ch] = 1'b1;
                anchor[ch]      = d1;
                push_msg(st, d1, d2);
            end else begin
                target[ch] = {1'b0, d1};
                start_glide(ch, int'(d1));
            end
            return;
        end
        if (!phrase_on[ch]) begin
            push_msg(st, d1, d2);
            return;
        end
        if (d1 == anchor[ch]) begin
            anchor_down[ch] = 1'b0;
            if (target[ch] != NO_TARGET)
                return;
            push_msg(st, d1, d2);
            recenter(ch);
            end_phrase(ch);
            return;
        end
        if (target[ch] != NO_TARGET && {1'b0, d1} == target[ch]) begin
            target[ch] = NO_TARGET;
            if (anchor_down[ch]) begin
                start_glide(ch, int'(anchor[ch]));
            end else begin
                push_msg(ST_NOTE_OFF | 8'(ch), anchor[ch], 7'd0);
                end_phrase(ch);
            end
        end
    endfunction

    function automatic void clear_model();
        glide_time   = '0;
        glide_smooth = 1'b0;
        for (int ch = 0; ch < 16; ch++) begin
            end_phrase(ch);
            range_semis[ch] = DEFAULT_BEND_RANGE;
            bend_q16[ch]    = 64 * ONE_Q16;
            sent_bend[ch]   = NEUTRAL;
        end
        expected_msgs.delete();
    endfunction

    initial begin
        fail_count   = 0;
        result_count = 0;
        clear_model();
    end

    assign pending_count = expected_msgs.size();

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            clear_model();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_BEND_TIME)
                    glide_time = cfg_wdata;
                else
                    glide_smooth = cfg_wdata[0];
            end
            if (s_valid && s_ready) begin
                new_msgs = 0;
                if (s_data.req_type)
                    advance_glides(s_data.elapsed_us);
                else
                    handle_event(s_data.midi_status, s_data.midi_data1, s_data.midi_data2);
                if (new_msgs > 0)
                    expected_msgs[expected_msgs.size() - 1].last_of_run = 1'b1;
            end
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_msgs.size() == 0) begin
                    $error("unexpected result %h", m_data);
                    fail_count++;
                end else begin
                    want = expected_msgs.pop_front();
                    if (m_data.out_status !== want.out_status) begin
                        $error("out_status: expected %h, got %h",
                               want.out_status, m_data.out_status);
                        fail_count++;
                    end
                    if (m_data.out_data1 !== want.out_data1) begin
                        $error("out_data1: expected %0d, got %0d",
                               want.out_data1, m_data.out_data1);
                        fail_count++;
                    end
                    if (m_data.out_data2 !== want.out_data2) begin
                        $error("out_data2: expected %0d, got %0d",
                               want.out_data2, m_data.out_data2);
                        fail_count++;
                    end
                    if (m_data.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %b, got %b",
                               want.last_of_run, m_data.last_of_run);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

@@ tb/tb_midi_legato_pitch_bend_glide.sv @@
`timescale 1ns / 1ps
// Top of the glide block testbench: clock, reset, config writes, stimulus and verdict.
// Depends on mlpbg_pkg, midi_legato_pitch_bend_glide and mlpbg_glide_checker.
module tb_midi_legato_pitch_bend_glide;
    import mlpbg_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int SETTLE_CYCLES  = 2000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [23:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_t         s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_t        m_data;

    int fail_count;
    int pending_count;
    int result_count;
    int items_sent   = 0;
    int idle_cycles  = 0;
    bit no_gaps      = 1'b0;
    bit long_hold    = 1'b0;
    bit hold_done    = 1'b0;
    int hold_left    = 0;
    logic [6:0] held_notes[$];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    midi_legato_pitch_bend_glide i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    mlpbg_glide_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    // The result side stalls at random and once holds off for a long stretch.
    always @(posedge aclk) begin
        if (long_hold && !hold_done) begin
            hold_left = 400;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (no_gaps) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 19) == 0 ? 1'b0
                       : 1'($urandom_range(0, 1)));
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_count);
            $display("tb_midi_legato_pitch_bend_glide: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [23:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_item(in_t it);
        int gap;
        s_valid <= 1'b1;
        s_data  <= it;
        @(negedge aclk);
        while (!s_ready)
            @(negedge aclk);
        @(posedge aclk);
        items_sent++;
        gap = 0;
        if (!no_gaps)
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_event(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
        in_t it;
        it = '0;
        it.req_type    = 1'b0;
        it.midi_status = st;
        it.midi_data1  = d1;
        it.midi_data2  = d2;
        send_item(it);
    endtask

    task automatic send_tick(logic [19:0] us);
        in_t it;
        it = '0;
        it.req_type   = 1'b1;
        it.elapsed_us = us;
        send_item(it);
    endtask

    task automatic send_random_item();
        in_t it;
        int pick;
        logic [3:0] ch;
        logic [6:0] note;
        pick = $urandom_range(0, 99);
        ch   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
        if (pick < 33) begin
            note = 7'($urandom_range(48, 76));
            if ($urandom_range(0, 15) == 0)
                note = ($urandom_range(0, 1) != 0) ? 7'd127 : 7'd0;
            held_notes.insert(held_notes.size(), note);
            send_event(ST_NOTE_ON | {4'h0, ch}, note, 7'($urandom_range(1, 127)));
        end else if (pick < 58) begin
            note = 7'($urandom_range(48, 76));
            if (held_notes.size() != 0) begin
                pick = $urandom_range(0, held_notes.size() - 1);
                note = held_notes[pick];
                held_notes.delete(pick);
            end
            if ($urandom_range(0, 2) == 0)
                send_event(ST_NOTE_ON | {4'h0, ch}, note, 7'd0);
            else
                send_event(ST_NOTE_OFF | {4'h0, ch}, note, 7'($urandom_range(0, 127)));
        end else if (pick < 85) begin
            send_tick(($urandom_range(0, 9) == 0) ? 20'($urandom()) : 20'($urandom_range(0, 500)));
        end else if (pick < 92) begin
            send_event(ST_CC | {4'h0, ch}, ($urandom_range(0, 2) != 0) ? CC_BEND_RANGE
                       : 7'($urandom_range(0, 127)), 7'($urandom_range(0, 24)));
        end else begin
            it = in_t'($urandom());
            it.elapsed_us = 20'($urandom());
            send_item(it);
        end
    endtask

    initial begin
        logic [23:0] times[7];
        logic        curves[7];
        times  = '{24'd1000, 24'd1000, 24'd1, 24'hFFFFFF, 24'd0, 24'd50000, 24'd200};
        curves = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_BEND_TIME, 24'd1000);
        write_reg(REG_CURVE, 24'd0);
        send_event(ST_CC | 8'd0, CC_BEND_RANGE, 7'd12);
        send_event(ST_NOTE_ON | 8'd0, 7'd60, 7'd100);
        send_event(ST_NOTE_ON | 8'd0, 7'd67, 7'd127);
        send_tick(20'd0);
        send_tick(20'd300);
        send_tick(20'd700);
        send_event(ST_NOTE_OFF | 8'd0, 7'd50, 7'd0);
        send_event(ST_NOTE_OFF | 8'd0, 7'd67, 7'd64);
        send_tick(20'hFFFFF);
        send_event(ST_NOTE_ON | 8'd0, 7'd72, 7'd1);
        send_event(ST_NOTE_ON | 8'd0, 7'd60, 7'd0);
        send_event(ST_NOTE_OFF | 8'd0, 7'd72, 7'd0);
        send_event(ST_CC | 8'd15, CC_BEND_RANGE, 7'd0);
        send_event(ST_NOTE_ON | 8'd15, 7'd0, 7'd127);
        send_event(ST_NOTE_ON | 8'd15, 7'd127, 7'd10);
        send_event(8'hC3, 7'd127, 7'd127);
        send_event(8'hFF, 7'd0, 7'd0);
        send_event(ST_CC | 8'd1, CC_BEND_RANGE, 7'd127);
        send_event(ST_NOTE_ON | 8'd1, 7'd0, 7'd90);
        send_event(ST_NOTE_ON | 8'd1, 7'd127, 7'd90);
        drain();

        // Turning the glide off mid-ramp: ticks must still finish the ramp.
        write_reg(REG_BEND_TIME, 24'd0);
        send_event(ST_NOTE_ON | 8'd1, 7'd5, 7'd5);
        send_tick(20'd400);
        send_tick(20'd700);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            write_reg(REG_BEND_TIME, times[ph]);
            write_reg(REG_CURVE, {23'd0, curves[ph]});
            no_gaps = (ph == 2);
            if (ph == 3)
                long_hold = 1'b1;
            held_notes.delete();
            for (int n = 0; n < 43; n++)
                send_random_item();
            drain();
        end
        no_gaps = 1'b0;

        $display("Sent %0d items over 9 glide settings and checked %0d results,",
                 items_sent, result_count);
        $display("covering linear and smoothstep ramps, pass-through and stalls.");
        if (fail_count == 0 && pending_count == 0)
            $display("tb_midi_legato_pitch_bend_glide: PASS");
        else
            $display("tb_midi_legato_pitch_bend_glide: FAIL");
        $finish;
    end
endmodule

@@ files.f @@
rtl/mlpbg_pkg.sv
rtl/mlpbg_queue.sv
rtl/mlpbg_front.sv
rtl/mlpbg_div.sv
rtl/mlpbg_back.sv
rtl/midi_legato_pitch_bend_glide.sv
tb/mlpbg_glide_checker.sv
tb/tb_midi_legato_pitch_bend_glide.sv
